// ===== rtl/rtlc_pkg.sv =====
// Shared constants, types and coefficient helpers for the lux and color temperature pipeline.
package rtlc_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int IN_BITS  = 16;
    localparam int OUT_BITS = 16;

    // McCamy ratio n is carried as magnitude with NQ fraction bits and NI integer bits.
    localparam int NQ = 24;
    localparam int NI = 3;
    localparam int QW = NQ + NI;

    // Polynomial accumulator widths (signed).
    localparam int AW1 = 38;
    localparam int AW2 = 41;
    localparam int AW3 = 44;

    localparam logic [OUT_BITS-1:0] OUT_MAX = 16'hFFFF;

    localparam logic [QW-1:0] N_LIMIT = QW'(64'd6 << NQ);
    localparam logic [QW-1:0] N_SAT   = {QW{1'b1}};

    localparam longint C3 = 449;
    localparam longint C2 = longint'(3525) << NQ;
    localparam longint C1 = ((longint'(68233) << NQ) + 5) / 10;
    localparam longint C0 = ((longint'(552033) << NQ) + 50) / 100;

    // Exact ratios 0.332 and 0.1858 scaled by 10000.
    localparam int X_NUM = 10000;
    localparam int S_NUM = 3320;
    localparam int S_DEN = 1858;
    localparam int Y_DEN = 10000;

    // Mixing matrix in units of 1e-5; rows give X, Y, Z, columns red, green, blue.
    localparam int MIX_E5 [3][3] = '{
        '{ -14282, 154924, -95641 },
        '{ -32466, 157837, -73191 },
        '{ -68202,  77073,  56332 }
    };

    typedef struct packed {
        logic [OUT_BITS-1:0] lux;
        logic                undef;
    } side_t;

    // Round a 1e-5 coefficient to fb fraction bits, halves away from zero.
    function automatic longint fixed_coef(input int e5, input int fb);
        longint m;
        longint q;
        m = (e5 < 0) ? -longint'(e5) : longint'(e5);
        q = ((m << fb) + 64'sd50000) / 64'sd100000;
        return (e5 < 0) ? -q : q;
    endfunction

endpackage

// ===== rtl/rgb_to_lux_and_color_temperature.sv =====
// Top level: stream handshake, pipeline stall control and port packing.
//
// Converts one raw red/green/blue sample per transaction into lux and a McCamy
// correlated color temperature in kelvin. A new sample is accepted every clock
// cycle while the output is not stalled; each passes 4 stages of color mixing,
// 29 stages of the bit-per-stage ratio divider (27 quotient bits plus two set-up
// stages) and 6 stages of cubic evaluation and output clamping. The whole
// pipeline holds when a result waits on the output, so s_axis_tready follows
// m_axis_tready then. temp_undefined flags a zero color sum or a zero McCamy
// denominator, and color_temp reads 0 in that case.
module rgb_to_lux_and_color_temperature
    import rtlc_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // lux, color_temp
    output logic [0:0]  m_axis_tuser    // temp_undefined
);

    localparam int NW = SAMPLE_BITS + FRACTION_BITS + 17;

    logic                 advance;
    logic                 mix_valid;
    logic signed [NW-1:0] mix_num;
    logic signed [NW-1:0] mix_den;
    side_t                mix_side;
    logic                 div_valid;
    logic [QW-1:0]        div_quot;
    logic                 div_sat;
    logic                 div_neg;
    side_t                div_side;
    logic [OUT_BITS-1:0]  lux;
    logic [OUT_BITS-1:0]  color_temp;
    logic                 temp_undefined;

    // Advance everything unless a finished result is still waiting.
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    rtlc_mix #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .NW            (NW)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .red       (s_axis_tdata[15:0]),
        .green     (s_axis_tdata[31:16]),
        .blue      (s_axis_tdata[47:32]),
        .out_valid (mix_valid),
        .num       (mix_num),
        .den       (mix_den),
        .side      (mix_side)
    );

    rtlc_div #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .NW            (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (mix_valid),
        .num       (mix_num),
        .den       (mix_den),
        .in_side   (mix_side),
        .out_valid (div_valid),
        .quot      (div_quot),
        .sat       (div_sat),
        .neg       (div_neg),
        .out_side  (div_side)
    );

    rtlc_poly u_poly (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (div_valid),
        .quot           (div_quot),
        .sat            (div_sat),
        .neg            (div_neg),
        .in_side        (div_side),
        .out_valid      (m_axis_tvalid),
        .lux            (lux),
        .color_temp     (color_temp),
        .temp_undefined (temp_undefined)
    );

    assign m_axis_tdata = {color_temp, lux};
    assign m_axis_tuser = temp_undefined;

    a_undef_zero_temp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[31:16] == 16'd0))
        else $error("undefined temperature with nonzero value");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with no result waiting");

endmodule

// ===== rtl/rtlc_mix.sv =====
// Color mixing front end: channel products, X/Y/Z sums, lux clamp, McCamy numerator and denominator.
module rtlc_mix
    import rtlc_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int NW            = SAMPLE_BITS + FRACTION_BITS + 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic [IN_BITS-1:0]   red,
    input  logic [IN_BITS-1:0]   green,
    input  logic [IN_BITS-1:0]   blue,
    output logic                 out_valid,
    output logic signed [NW-1:0] num,
    output logic signed [NW-1:0] den,
    output side_t                side
);

    localparam int CW = FRACTION_BITS + 2;
    localparam int PW = SAMPLE_BITS + FRACTION_BITS + 2;
    localparam int XW = SAMPLE_BITS + FRACTION_BITS + 3;
    localparam int SW = SAMPLE_BITS + FRACTION_BITS + 4;

    logic signed [CW-1:0]      coef [3][3];
    logic [SAMPLE_BITS-1:0]    ch [3];
    logic signed [PW-1:0]      prod_next [3][3];
    logic signed [PW-1:0]      prod_reg [3][3];
    logic signed [XW-1:0]      xyz_next [3];
    logic signed [XW-1:0]      xyz_reg [3];
    logic signed [SW-1:0]      s_next;
    logic signed [SW-1:0]      s_reg;
    logic signed [XW-1:0]      x_reg;
    logic signed [XW-1:0]      y_reg;
    logic [XW-1:0]             y_int;
    logic [OUT_BITS-1:0]       lux_next;
    logic [OUT_BITS-1:0]       lux3_reg;
    logic                      szero_reg;
    logic signed [NW-1:0]      num_next;
    logic signed [NW-1:0]      den_next;
    logic signed [NW-1:0]      num_reg;
    logic signed [NW-1:0]      den_reg;
    side_t                     side_reg;
    logic [3:0]                vld_reg;

    assign ch[0] = red[SAMPLE_BITS-1:0];
    assign ch[1] = green[SAMPLE_BITS-1:0];
    assign ch[2] = blue[SAMPLE_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                coef[i][j]      = CW'(fixed_coef(MIX_E5[i][j], FRACTION_BITS));
                prod_next[i][j] = coef[i][j] * $signed({1'b0, ch[j]});
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xyz_next[i] = XW'(prod_reg[i][0]) + XW'(prod_reg[i][1]) + XW'(prod_reg[i][2]);
        end
    end

    assign s_next = SW'(xyz_reg[0]) + SW'(xyz_reg[1]) + SW'(xyz_reg[2]);

    // Truncate Y toward zero, clamp to the output range.
    always_comb
    begin
        y_int = XW'(xyz_reg[1] >>> FRACTION_BITS);
        if (xyz_reg[1] <= 0)
        begin
            lux_next = '0;
        end
        else if (y_int > XW'(OUT_MAX))
        begin
            lux_next = OUT_MAX;
        end
        else
        begin
            lux_next = y_int[OUT_BITS-1:0];
        end
    end

    assign num_next = NW'(X_NUM) * NW'(x_reg) - NW'(S_NUM) * NW'(s_reg);
    assign den_next = NW'(S_DEN) * NW'(s_reg) - NW'(Y_DEN) * NW'(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg        <= prod_next;
            xyz_reg         <= xyz_next;
            s_reg           <= s_next;
            x_reg           <= xyz_reg[0];
            y_reg           <= xyz_reg[1];
            lux3_reg        <= lux_next;
            szero_reg       <= (s_next == '0);
            num_reg         <= num_next;
            den_reg         <= den_next;
            side_reg.lux    <= lux3_reg;
            side_reg.undef  <= szero_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

// ===== rtl/rtlc_div.sv =====
// Pipelined restoring divider: magnitude of the McCamy ratio, one quotient bit per stage.
module rtlc_div
    import rtlc_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int NW            = SAMPLE_BITS + FRACTION_BITS + 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] num,
    input  logic signed [NW-1:0] den,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic [QW-1:0]        quot,
    output logic                 sat,
    output logic                 neg,
    output side_t                out_side
);

    localparam int MW = NW - 1;
    localparam int DW = MW + 3;

    typedef struct packed {
        logic [DW-1:0] r;
        logic [DW-1:0] d;
        logic [QW-1:0] q;
        logic          sat;
        logic          neg;
        side_t         side;
    } step_t;

    logic [MW-1:0] un_reg;
    logic [MW-1:0] ud_reg;
    logic          neg0_reg;
    side_t         side0_reg;
    logic          vld0_reg;
    step_t         step_next0;
    step_t         step_reg [QW+1];
    logic [QW:0]   vld_reg;

    // Scale the divisor by eight so the quotient has three integer bits.
    always_comb
    begin
        step_next0.r    = {3'b000, un_reg};
        step_next0.d    = {ud_reg, 3'b000};
        step_next0.q    = '0;
        step_next0.sat  = ({3'b000, un_reg} >= {ud_reg, 3'b000});
        step_next0.neg  = neg0_reg;
        step_next0.side = side0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld0_reg   <= in_valid;
            vld_reg[0] <= vld0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            un_reg          <= num[NW-1] ? MW'(-num) : MW'(num);
            ud_reg          <= den[NW-1] ? MW'(-den) : MW'(den);
            neg0_reg        <= num[NW-1] ^ den[NW-1];
            side0_reg.lux   <= in_side.lux;
            side0_reg.undef <= in_side.undef | (den == '0);
            step_reg[0]     <= step_next0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW:0] t;
        logic        ge;
        step_t       step_next;

        always_comb
        begin
            t         = {step_reg[k].r, 1'b0};
            ge        = (t >= {1'b0, step_reg[k].d});
            step_next = step_reg[k];
            step_next.r = ge ? DW'(t - {1'b0, step_reg[k].d}) : t[DW-1:0];
            step_next.q = {step_reg[k].q[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                step_reg[k+1] <= step_next;
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quot      = step_reg[QW].q;
    assign sat       = step_reg[QW].sat;
    assign neg       = step_reg[QW].neg;
    assign out_side  = step_reg[QW].side;

endmodule

// ===== rtl/rtlc_poly.sv =====
// McCamy cubic in Horner form with split multipliers, then clamp into the output register.
module rtlc_poly
    import rtlc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [QW-1:0]       quot,
    input  logic                sat,
    input  logic                neg,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [OUT_BITS-1:0] lux,
    output logic [OUT_BITS-1:0] color_temp,
    output logic                temp_undefined
);

    localparam logic signed [AW1-1:0] C3_Q = AW1'(C3);
    localparam logic signed [AW1-1:0] C2_Q = AW1'(C2);
    localparam logic signed [AW2-1:0] C1_Q = AW2'(C1);
    localparam logic signed [AW3-1:0] C0_Q = AW3'(C0);
    localparam int L1 = 18;
    localparam int L2 = 20;

    logic [QW-1:0]          nmag_next;
    logic signed [AW1-1:0]  t1;
    logic signed [AW1-1:0]  acc1_next;
    logic [AW1-2:0]         amag1;
    logic [AW2-2:0]         m1;
    logic signed [AW2-1:0]  ms1;
    logic signed [AW2-1:0]  acc2_next;
    logic [AW2-2:0]         amag2;
    logic [AW3-2:0]         m2;
    logic signed [AW3-1:0]  ms2;
    logic signed [AW3-1:0]  acc3_next;
    logic [AW3-2:0]         w_int;
    logic [OUT_BITS-1:0]    cct_next;

    logic [5:0]             vld_reg;
    side_t                  side_reg [5];
    logic [QW-1:0]          nmag_reg [3];
    logic                   nneg_reg [3];
    logic signed [AW1-1:0]  acc1_reg;
    logic                   sgn2_reg;
    logic [L1+QW-1:0]       pl1_reg;
    logic [AW1-1-L1+QW-1:0] ph1_reg;
    logic signed [AW2-1:0]  acc2_reg;
    logic                   sgn4_reg;
    logic [L2+QW-1:0]       pl2_reg;
    logic [AW2-1-L2+QW-1:0] ph2_reg;
    logic signed [AW3-1:0]  acc3_reg;
    logic [OUT_BITS-1:0]    lux_reg;
    logic [OUT_BITS-1:0]    cct_reg;
    logic                   undef_reg;

    // Limit n to six in magnitude; the cubic saturates the output beyond that.
    assign nmag_next = (sat || (quot > N_LIMIT)) ? N_LIMIT : quot;
    assign t1        = C3_Q * $signed({1'b0, (AW1-1)'(nmag_next)});
    assign acc1_next = neg ? (C2_Q - t1) : (C2_Q + t1);

    assign amag1 = acc1_reg[AW1-1] ? (AW1-1)'(-acc1_reg) : acc1_reg[AW1-2:0];
    assign m1    = (AW2-1)'(({ph1_reg, {L1{1'b0}}} + (L1+AW1-1-L1+QW)'(pl1_reg)) >> NQ);
    assign ms1   = $signed({1'b0, m1});
    assign acc2_next = sgn2_reg ? (C1_Q - ms1) : (C1_Q + ms1);

    assign amag2 = acc2_reg[AW2-1] ? (AW2-1)'(-acc2_reg) : acc2_reg[AW2-2:0];
    assign m2    = (AW3-1)'(({ph2_reg, {L2{1'b0}}} + (L2+AW2-1-L2+QW)'(pl2_reg)) >> NQ);
    assign ms2   = $signed({1'b0, m2});
    assign acc3_next = sgn4_reg ? (C0_Q - ms2) : (C0_Q + ms2);

    always_comb
    begin
        w_int = (AW3-1)'(acc3_reg[AW3-2:0] >> NQ);
        if (side_reg[4].undef || acc3_reg <= 0)
        begin
            cct_next = '0;
        end
        else if (w_int > (AW3-1)'(OUT_MAX))
        begin
            cct_next = OUT_MAX;
        end
        else
        begin
            cct_next = w_int[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= in_side;
            nmag_reg[0] <= nmag_next;
            nneg_reg[0] <= neg;
            acc1_reg    <= acc1_next;
            for (int i = 1; i < 5; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 1; i < 3; i++)
            begin
                nmag_reg[i] <= nmag_reg[i-1];
                nneg_reg[i] <= nneg_reg[i-1];
            end
            sgn2_reg  <= acc1_reg[AW1-1] ^ nneg_reg[0];
            pl1_reg   <= amag1[L1-1:0] * nmag_reg[0];
            ph1_reg   <= amag1[AW1-2:L1] * nmag_reg[0];
            acc2_reg  <= acc2_next;
            sgn4_reg  <= acc2_reg[AW2-1] ^ nneg_reg[2];
            pl2_reg   <= amag2[L2-1:0] * nmag_reg[2];
            ph2_reg   <= amag2[AW2-2:L2] * nmag_reg[2];
            acc3_reg  <= acc3_next;
            lux_reg   <= side_reg[4].lux;
            undef_reg <= side_reg[4].undef;
            cct_reg   <= cct_next;
        end
    end

    assign out_valid      = vld_reg[5];
    assign lux            = lux_reg;
    assign color_temp     = cct_reg;
    assign temp_undefined = undef_reg;

    a_acc1_positive: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (!acc1_reg[AW1-1] && acc1_reg != '0))
        else $error("first Horner term not positive");

    a_n_limited: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (nmag_reg[0] <= N_LIMIT))
        else $error("ratio magnitude above limit");

endmodule
